@@ rtl/isu_pkg.sv @@
// package: shared types and constants of the ising metropolis site update unit
`timescale 1ns / 1ps
`default_nettype none

package isu_pkg;

    localparam int ROW_W    = 5;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DE_W     = 5;
    localparam int ENERGY_W = 14;
    localparam int MAG_W    = 12;
    localparam int FRAC_W   = 16;
    localparam int SIDE_IN_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_EIGHT = 2'd3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_TRIAL = 1'b1;

    localparam logic signed [ENERGY_W:0] ENERGY_MAX = 15'sd8191;
    localparam logic signed [ENERGY_W:0] ENERGY_MIN = -15'sd8192;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NEIGH,
        ST_CALC
    } isu_state_t;

endpackage

`default_nettype wire

@@ rtl/ising_metropolis_site_update_unit.sv @@
// Metropolis site update for a square Ising lattice with periodic wrap.
// Input channel (in_valid / in_stall) carries one load or trial item per
// transfer; output channel (out_valid / out_stall) returns one result per item.
// The lattice is held as one row per memory word, two read ports, one write
// port, read data registered.
// A load reads its row, then modifies it and writes it back; a trial needs
// the two wrapped neighbour rows and the site row: three row reads over the
// two read ports, then the write-back.
// Loads and bad indexes go from IDLE straight to CALC; trials pass through
// NEIGH first. The result is registered when CALC completes.
// A finished result waits in the output register; the next item is taken
// meanwhile, but its write-back waits until the output register is free.
// After reset, and after every write of lattice_side, a clearing pass sets all
// spins down, one row a cycle, with in_stall held high.
// Configuration writes (cfg_write, cfg_index, cfg_data) are taken in any cycle.
`timescale 1ns / 1ps
`default_nettype none

module ising_metropolis_site_update_unit
    import isu_pkg::*;
#(
    parameter int MAX_SIDE    = 32,
    parameter int RANDOM_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_data,
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic                        kind,
    input  wire logic [ROW_W-1:0]            row,
    input  wire logic [ROW_W-1:0]            column,
    input  wire logic                        spin_value,
    input  wire logic [FRAC_W-1:0]           random_fraction,
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic                        flipped,
    output      logic                        spin_after,
    output      logic signed [DE_W-1:0]      energy_change,
    output      logic signed [ENERGY_W-1:0]  running_energy,
    output      logic signed [MAG_W-1:0]     magnetization,
    output      logic                        bad_index
);

    localparam int IDX_W      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int RND_W      = (RANDOM_BITS < FRAC_W) ? RANDOM_BITS : FRAC_W;
    localparam int RESET_SIDE = (MAX_SIDE < 32) ? MAX_SIDE : 32;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(RESET_SIDE);
    localparam logic [MAG_W-1:0]  MAG_RESET  = MAG_W'(-(RESET_SIDE * RESET_SIDE));
    localparam logic [9:0]        SIDE_MIN10 = 10'd3;
    localparam logic [9:0]        SIDE_MAX10 = 10'(MAX_SIDE);
    localparam logic [IDX_W-1:0]  LAST_ROW   = IDX_W'(MAX_SIDE - 1);

    // configuration
    logic [SIDE_W-1:0]     side_reg;
    logic                  coupling_reg;
    logic [FRAC_W-1:0]     thr_four_reg;
    logic [FRAC_W-1:0]     thr_eight_reg;

    // block state
    isu_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic signed [ENERGY_W-1:0] esum_reg, esum_next;
    logic signed [MAG_W-1:0]    mag_reg, mag_next;

    // item held during its work
    logic                  kind_reg;
    logic                  bad_reg;
    logic                  sv_reg;
    logic [IDX_W-1:0]      row_reg;
    logic [IDX_W-1:0]      col_reg;
    logic [IDX_W-1:0]      cp_reg;
    logic [IDX_W-1:0]      cn_reg;
    logic [IDX_W-1:0]      rn_reg;
    logic [RND_W-1:0]      rnd_reg;
    logic                  nb_up_reg;

    // output register
    logic                  out_valid_reg;
    logic                  flipped_reg;
    logic                  spin_after_reg;
    logic signed [DE_W-1:0] de_reg;
    logic                  bad_out_reg;

    // lattice memory
    logic [MAX_SIDE-1:0]   lattice_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0]   rd0_reg;
    logic [MAX_SIDE-1:0]   rd1_reg;
    logic                  rd0_en;
    logic                  rd1_en;
    logic [IDX_W-1:0]      rd0_addr;
    logic [IDX_W-1:0]      rd1_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [MAX_SIDE-1:0]   mem_wdata;

    // control
    logic                  in_xfer;
    logic                  side_wr;
    logic                  clr_last;
    logic                  calc_go;

    // configuration write decode
    logic [9:0]            side_in10;
    logic [9:0]            side_sat10;
    logic [17:0]           side_sq;
    logic [MAG_W-1:0]      mag_init;

    // input address decode
    logic [9:0]            side10;
    logic [9:0]            row10;
    logic [9:0]            col10;
    logic                  in_bad;
    logic [IDX_W-1:0]      row_i;
    logic [IDX_W-1:0]      col_i;
    logic [IDX_W-1:0]      rp_i;
    logic [IDX_W-1:0]      rn_i;
    logic [IDX_W-1:0]      cp_i;
    logic [IDX_W-1:0]      cn_i;
    logic [IDX_W-1:0]      side_m1;

    // site calculation
    logic                  s_bit;
    logic [2:0]            aligned;
    logic [2:0]            k_cnt;
    logic signed [DE_W-1:0] de_calc;
    logic                  accept;
    logic                  new_bit;
    logic                  res_flip;
    logic                  res_spin;
    logic signed [DE_W-1:0] res_de;
    logic signed [ENERGY_W:0] esum_sum;

    assign in_xfer  = in_valid && !in_stall;
    assign side_wr  = cfg_write && (cfg_index == CFG_SIDE);
    assign clr_last = (clr_cnt_reg == LAST_ROW);
    assign calc_go  = !out_valid_reg || !out_stall;

    always_comb
    begin
        side_in10 = {4'b0000, cfg_data[SIDE_IN_W-1:0]};
        if (side_in10 < SIDE_MIN10)
        begin
            side_sat10 = SIDE_MIN10;
        end
        else if (side_in10 > SIDE_MAX10)
        begin
            side_sat10 = SIDE_MAX10;
        end
        else
        begin
            side_sat10 = side_in10;
        end
        side_sq  = 18'(side_sat10[8:0]) * 18'(side_sat10[8:0]);
        mag_init = MAG_W'(18'd0 - side_sq);
    end

    always_comb
    begin
        side10  = 10'(side_reg);
        row10   = 10'(row);
        col10   = 10'(column);
        in_bad  = (row10 >= side10) || (col10 >= side10);
        row_i   = row10[IDX_W-1:0];
        col_i   = col10[IDX_W-1:0];
        side_m1 = IDX_W'(side10 - 10'd1);
        rp_i    = (row_i == '0) ? side_m1 : IDX_W'(row10 - 10'd1);
        rn_i    = ((row10 + 10'd1) >= side10) ? '0 : IDX_W'(row10 + 10'd1);
        cp_i    = (col_i == '0) ? side_m1 : IDX_W'(col10 - 10'd1);
        cn_i    = ((col10 + 10'd1) >= side10) ? '0 : IDX_W'(col10 + 10'd1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (kind == KIND_TRIAL && !in_bad) ? ST_NEIGH : ST_CALC;
                end
            end
            ST_NEIGH:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (calc_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (side_wr)
        begin
            state_next = ST_CLEAR;
        end
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        rd0_en    = 1'b0;
        rd1_en    = 1'b0;
        rd0_addr  = rp_i;
        rd1_addr  = row_i;
        mem_we    = 1'b0;
        mem_waddr = row_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                rd0_en   = in_valid;
                rd1_en   = in_valid;
            end
            ST_NEIGH:
            begin
                rd0_en   = 1'b1;
                rd0_addr = rn_reg;
            end
            ST_CALC:
            begin
                mem_we = calc_go && !bad_reg && ((kind_reg == KIND_LOAD) || accept);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // site calculation from the registered rows
    always_comb
    begin
        s_bit   = rd1_reg[col_reg];
        aligned = 3'(nb_up_reg ~^ s_bit) + 3'(rd0_reg[col_reg] ~^ s_bit)
                + 3'(rd1_reg[cp_reg] ~^ s_bit) + 3'(rd1_reg[cn_reg] ~^ s_bit);
        k_cnt   = coupling_reg ? (3'd4 - aligned) : aligned;
        de_calc = $signed({k_cnt, 2'b00}) - 5'sd8;
        priority if (k_cnt <= 3'd2)
        begin
            accept = 1'b1;
        end
        else if (k_cnt == 3'd3)
        begin
            accept = rnd_reg < thr_four_reg[RND_W-1:0];
        end
        else
        begin
            accept = rnd_reg < thr_eight_reg[RND_W-1:0];
        end
        new_bit   = (kind_reg == KIND_LOAD) ? sv_reg : (accept ? !s_bit : s_bit);
        mem_wdata = rd1_reg;
        mem_wdata[col_reg] = new_bit;
        if (state_reg == ST_CLEAR)
        begin
            mem_wdata = '0;
        end
        priority if (bad_reg)
        begin
            res_flip = 1'b0;
            res_spin = 1'b0;
            res_de   = '0;
        end
        else if (kind_reg == KIND_LOAD)
        begin
            res_flip = 1'b0;
            res_spin = sv_reg;
            res_de   = '0;
        end
        else
        begin
            res_flip = accept;
            res_spin = new_bit;
            res_de   = de_calc;
        end
        esum_sum = $signed({esum_reg[ENERGY_W-1], esum_reg}) + (ENERGY_W + 1)'(de_calc);
    end

    // running energy and magnetization
    always_comb
    begin
        esum_next = esum_reg;
        mag_next  = mag_reg;
        if (side_wr)
        begin
            esum_next = '0;
            mag_next  = mag_init;
        end
        else if (state_reg == ST_CALC && calc_go && !bad_reg)
        begin
            if (kind_reg == KIND_LOAD)
            begin
                esum_next = '0;
                if (sv_reg && !s_bit)
                begin
                    mag_next = mag_reg + 12'sd2;
                end
                else if (!sv_reg && s_bit)
                begin
                    mag_next = mag_reg - 12'sd2;
                end
            end
            else if (accept)
            begin
                mag_next = s_bit ? (mag_reg - 12'sd2) : (mag_reg + 12'sd2);
                if (esum_sum > ENERGY_MAX)
                begin
                    esum_next = ENERGY_MAX[ENERGY_W-1:0];
                end
                else if (esum_sum < ENERGY_MIN)
                begin
                    esum_next = ENERGY_MIN[ENERGY_W-1:0];
                end
                else
                begin
                    esum_next = esum_sum[ENERGY_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        clr_cnt_next = '0;
        if (state_reg == ST_CLEAR && !side_wr && !clr_last)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            side_reg      <= SIDE_RESET;
            coupling_reg  <= 1'b0;
            thr_four_reg  <= '0;
            thr_eight_reg <= '0;
            esum_reg      <= '0;
            mag_reg       <= MAG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            esum_reg    <= esum_next;
            mag_reg     <= mag_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SIDE:      side_reg      <= SIDE_W'(side_sat10);
                    CFG_COUPLING:  coupling_reg  <= cfg_data[0];
                    CFG_THR_FOUR:  thr_four_reg  <= cfg_data;
                    CFG_THR_EIGHT: thr_eight_reg <= cfg_data;
                    default:       coupling_reg  <= coupling_reg;
                endcase
            end
            if (state_reg == ST_CALC && calc_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= kind;
            bad_reg  <= in_bad;
            sv_reg   <= spin_value;
            row_reg  <= row_i;
            col_reg  <= col_i;
            cp_reg   <= cp_i;
            cn_reg   <= cn_i;
            rn_reg   <= rn_i;
            rnd_reg  <= random_fraction[RND_W-1:0];
        end
        if (state_reg == ST_NEIGH)
        begin
            nb_up_reg <= rd0_reg[col_reg];
        end
        if (state_reg == ST_CALC && calc_go)
        begin
            flipped_reg    <= res_flip;
            spin_after_reg <= res_spin;
            de_reg         <= res_de;
            bad_out_reg    <= bad_reg;
        end
    end

    // lattice rows
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lattice_mem[mem_waddr] <= mem_wdata;
        end
        if (rd0_en)
        begin
            rd0_reg <= lattice_mem[rd0_addr];
        end
        if (rd1_en)
        begin
            rd1_reg <= lattice_mem[rd1_addr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign flipped        = flipped_reg;
    assign spin_after     = spin_after_reg;
    assign energy_change  = de_reg;
    assign running_energy = esum_reg;
    assign magnetization  = mag_reg;
    assign bad_index      = bad_out_reg;

`ifndef SYNTHESIS
    a_trial_reads_neighbours: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && kind == KIND_TRIAL && !in_bad && !side_wr) |=> (state_reg == ST_NEIGH))
        else $error("trial transfer did not start the neighbour row read");

    a_side_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        side_wr |=> (state_reg == ST_CLEAR && clr_cnt_reg == '0))
        else $error("lattice side write did not restart the clearing pass");

    a_clear_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |-> (clr_cnt_reg == '0))
        else $error("clearing counter moved outside the clearing pass");

    a_bad_no_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_out_reg) |-> (!flipped_reg && !spin_after_reg && de_reg == '0))
        else $error("ignored item reported a spin change");

    a_energy_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (de_reg[1:0] == 2'b00))
        else $error("energy change is not a multiple of four");
`endif

endmodule

`default_nettype wire

@@ test/ising_metropolis_site_update_unit_test.sv @@
// testbench: random and directed load and trial items against a lattice predictor
`timescale 1ns / 1ps

module ising_metropolis_site_update_unit_test;
    import isu_pkg::*;

    localparam int LATTICE_MAX = 32;
    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic                       flipped;
        logic                       spin_after;
        logic signed [DE_W-1:0]     energy_change;
        logic signed [ENERGY_W-1:0] running_energy;
        logic signed [MAG_W-1:0]    magnetization;
        logic                       bad_index;
    } site_outcome_t;

    class lattice_scoreboard;
        bit                      spins [LATTICE_MAX][LATTICE_MAX];
        int                      side;
        bit                      antiferro;
        bit [FRAC_W-1:0]         thr_four;
        bit [FRAC_W-1:0]         thr_eight;
        int                      energy_sum;
        logic signed [MAG_W-1:0] spin_total;
        site_outcome_t           pending_outcomes [$];
        int                      errors;

        function new();
            side      = LATTICE_MAX;
            antiferro = 1'b0;
            thr_four  = '0;
            thr_eight = '0;
            errors    = 0;
            clear_lattice();
        endfunction

        function void clear_lattice();
            for (int r = 0; r < LATTICE_MAX; r++)
                for (int c = 0; c < LATTICE_MAX; c++)
                    spins[r][c] = 1'b0;
            energy_sum = 0;
            spin_total = MAG_W'(-(side * side));
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_SIDE:
                begin
                    side = int'(data[SIDE_IN_W-1:0]);
                    if (side < 3)
                        side = 3;
                    if (side > LATTICE_MAX)
                        side = LATTICE_MAX;
                    clear_lattice();
                end
                CFG_COUPLING:  antiferro = data[0];
                CFG_THR_FOUR:  thr_four = data;
                CFG_THR_EIGHT: thr_eight = data;
            endcase
        endfunction

        function int spin_sign(int r, int c);
            return spins[r][c] ? 1 : -1;
        endfunction

        function void note_item(logic k, logic [ROW_W-1:0] r, logic [ROW_W-1:0] c, logic sv,
                                logic [FRAC_W-1:0] frac);
            site_outcome_t want;
            int row_i, col_i, up, down, left, right, s, around, de;
            bit take;
            want  = '0;
            row_i = int'(r);
            col_i = int'(c);
            if (row_i >= side || col_i >= side)
                want.bad_index = 1'b1;
            else if (k == KIND_LOAD)
            begin
                spin_total = spin_total + MAG_W'((sv ? 1 : -1) - spin_sign(row_i, col_i));
                spins[row_i][col_i] = sv;
                energy_sum = 0;
                want.spin_after = sv;
            end
            else
            begin
                up     = (row_i == 0) ? side - 1 : row_i - 1;
                down   = (row_i + 1 >= side) ? 0 : row_i + 1;
                left   = (col_i == 0) ? side - 1 : col_i - 1;
                right  = (col_i + 1 >= side) ? 0 : col_i + 1;
                s      = spin_sign(row_i, col_i);
                around = spin_sign(up, col_i) + spin_sign(down, col_i)
                       + spin_sign(row_i, left) + spin_sign(row_i, right);
                de     = antiferro ? -2 * s * around : 2 * s * around;
                if (de <= 0)
                    take = 1'b1;
                else if (de == 4)
                    take = frac < thr_four;
                else
                    take = frac < thr_eight;
                if (take)
                begin
                    s = -s;
                    spins[row_i][col_i] = (s > 0);
                    spin_total = spin_total + MAG_W'(2 * s);
                    energy_sum = energy_sum + de;
                    if (energy_sum > ENERGY_MAX)
                        energy_sum = ENERGY_MAX;
                    if (energy_sum < ENERGY_MIN)
                        energy_sum = ENERGY_MIN;
                    want.flipped = 1'b1;
                end
                want.spin_after    = (s > 0);
                want.energy_change = DE_W'(de);
            end
            want.running_energy = ENERGY_W'(energy_sum);
            want.magnetization  = spin_total;
            pending_outcomes.push_back(want);
        endfunction

        function void compare_field(string name, logic signed [15:0] want,
                                    logic signed [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(site_outcome_t got);
            site_outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                $error("result transfer with no item outstanding");
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("flipped", want.flipped, got.flipped);
            compare_field("spin_after", want.spin_after, got.spin_after);
            compare_field("energy_change", $signed(want.energy_change),
                          $signed(got.energy_change));
            compare_field("running_energy", $signed(want.running_energy),
                          $signed(got.running_energy));
            compare_field("magnetization", $signed(want.magnetization),
                          $signed(got.magnetization));
            compare_field("bad_index", want.bad_index, got.bad_index);
        endfunction
    endclass

    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       cfg_write       = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index       = CFG_SIDE;
    logic [CFG_W-1:0]           cfg_data        = '0;
    logic                       in_valid        = 1'b0;
    logic                       in_stall;
    logic                       kind            = KIND_LOAD;
    logic [ROW_W-1:0]           row             = '0;
    logic [ROW_W-1:0]           column          = '0;
    logic                       spin_value      = 1'b0;
    logic [FRAC_W-1:0]          random_fraction = '0;
    logic                       out_valid;
    logic                       out_stall       = 1'b0;
    logic                       flipped;
    logic                       spin_after;
    logic signed [DE_W-1:0]     energy_change;
    logic signed [ENERGY_W-1:0] running_energy;
    logic signed [MAG_W-1:0]    magnetization;
    logic                       bad_index;

    lattice_scoreboard board;
    int idle_odds    = 5;
    int holds_asked  = 0;
    int holds_served = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int cycle_count  = 0;
    int sent_total   = 0;

    ising_metropolis_site_update_unit DUT (.*);

    always #1 clk = ~clk;

    // result side: check each transfer, then decide the stall for the next cycle
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_result({flipped, spin_after, energy_change, running_energy,
                                magnetization, bad_index});
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            out_stall    <= 1'b1;
            holds_served <= holds_asked;
            hold_left    <= HOLD_CYCLES;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(16, 0);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic sender_pause();
        int gap;
        if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0)
        begin
            gap = $urandom_range(17, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_item(logic k, int r, int c, logic sv, logic [FRAC_W-1:0] frac);
        sender_pause();
        in_valid        <= 1'b1;
        kind            <= k;
        row             <= ROW_W'(r);
        column          <= ROW_W'(c);
        spin_value      <= sv;
        random_fraction <= frac;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        board.note_item(k, ROW_W'(r), ROW_W'(c), sv, frac);
        sent_total++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_outcomes.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.write_register(index, value);
        @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_threshold();
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // fresh lattice, random settings, a loaded pattern, then mostly trials
    task automatic run_phase(int side_code, int items);
        int n, pick, r, c;
        write_reg(CFG_SIDE, CFG_W'(side_code) | (CFG_W'($urandom) & 16'hFFC0));
        write_reg(CFG_COUPLING, CFG_W'($urandom));
        write_reg(CFG_THR_FOUR, pick_threshold());
        write_reg(CFG_THR_EIGHT, pick_threshold());
        n = board.side;
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(99, 0);
            r = $urandom_range(n - 1, 0);
            c = $urandom_range(n - 1, 0);
            if (pick < 8 && n < LATTICE_MAX)
            begin
                if ($urandom_range(1, 0))
                    r = $urandom_range(LATTICE_MAX - 1, n);
                else
                    c = $urandom_range(LATTICE_MAX - 1, n);
                offer_item(1'($urandom_range(1, 0)), r, c, 1'($urandom_range(1, 0)),
                           FRAC_W'($urandom));
            end
            else if (i < items / 3 || pick < 14)
                offer_item(KIND_LOAD, r, c, 1'($urandom_range(1, 0)), FRAC_W'($urandom));
            else
                offer_item(KIND_TRIAL, r, c, 1'($urandom_range(1, 0)), FRAC_W'($urandom));
        end
        drain();
    endtask

    // trials on one checkerboard sublattice of the full lattice
    task automatic sweep_sites(int parity, int limit);
        int count;
        count = 0;
        for (int r = 0; r < LATTICE_MAX; r++)
            for (int c = 0; c < LATTICE_MAX; c++)
                if ((r + c) % 2 == parity && count < limit)
                begin
                    offer_item(KIND_TRIAL, r, c, 1'($urandom_range(1, 0)), FRAC_W'($urandom));
                    count++;
                end
        drain();
    endtask

    initial
    begin
        int phase, side_code;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero thresholds never accept a positive change
        offer_item(KIND_TRIAL, 0, 0, 1'b1, 16'h0000);
        offer_item(KIND_LOAD, 31, 31, 1'b1, 16'hFFFF);
        offer_item(KIND_LOAD, 0, 31, 1'b1, 16'h0000);
        offer_item(KIND_TRIAL, 0, 0, 1'b0, 16'hFFFF);
        offer_item(KIND_TRIAL, 31, 31, 1'b0, 16'h0000);
        offer_item(KIND_LOAD, 31, 31, 1'b0, 16'h8000);
        drain();

        write_reg(CFG_COUPLING, 16'hFFFF);
        write_reg(CFG_THR_FOUR, 16'hFFFF);
        write_reg(CFG_THR_EIGHT, 16'hFFFF);
        offer_item(KIND_TRIAL, 5, 5, 1'b0, 16'hFFFE);
        offer_item(KIND_TRIAL, 5, 5, 1'b0, 16'hFFFF);
        offer_item(KIND_TRIAL, 5, 5, 1'b0, 16'hFFFE);
        offer_item(KIND_LOAD, 10, 9, 1'b1, 16'h0000);
        offer_item(KIND_LOAD, 10, 11, 1'b1, 16'h0000);
        offer_item(KIND_TRIAL, 10, 10, 1'b1, 16'h1234);
        offer_item(KIND_TRIAL, 10, 9, 1'b0, 16'h0000);
        drain();

        // side below range saturates to three
        write_reg(CFG_SIDE, 16'hFFC2);
        write_reg(CFG_COUPLING, 16'h0000);
        offer_item(KIND_TRIAL, 3, 0, 1'b0, 16'h0000);
        offer_item(KIND_LOAD, 0, 31, 1'b1, 16'h0000);
        offer_item(KIND_TRIAL, 31, 31, 1'b1, 16'hFFFF);
        offer_item(KIND_LOAD, 2, 0, 1'b1, 16'h0000);
        offer_item(KIND_LOAD, 0, 2, 1'b1, 16'h0000);
        offer_item(KIND_TRIAL, 0, 0, 1'b0, 16'h0000);
        offer_item(KIND_TRIAL, 2, 2, 1'b1, 16'hFFFF);
        drain();

        phase = 0;
        while (sent_total < 470)
        begin
            idle_odds = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 2);
            if (phase == 1)
                holds_asked++;
            case ($urandom_range(4, 0))
                0:       side_code = $urandom_range(2, 0);
                1:       side_code = $urandom_range(63, 33);
                2:       side_code = LATTICE_MAX;
                3:       side_code = $urandom_range(6, 3);
                default: side_code = $urandom_range(LATTICE_MAX, 3);
            endcase
            if (phase == 0)
                side_code = 0;
            run_phase(side_code, $urandom_range(60, 20));
            phase++;
        end

        // drive the running energy into its lower clamp by alternating coupling
        idle_odds = 6;
        write_reg(CFG_SIDE, CFG_W'(LATTICE_MAX));
        write_reg(CFG_COUPLING, 16'h0001);
        holds_asked++;
        sweep_sites(0, LATTICE_MAX * LATTICE_MAX);
        write_reg(CFG_COUPLING, 16'h0000);
        sweep_sites(1, LATTICE_MAX * LATTICE_MAX);
        write_reg(CFG_COUPLING, 16'h0001);
        sweep_sites(0, 64);

        idle_odds = 0;
        run_phase(63, 100);

        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
